// ===== design/ascr_pkg.sv =====
// ----------------------------------------------------------------------------
// ascr_pkg: shared types and constants of the slide collision resolver
// Item and result structs, configuration register indexes, fixed widths,
// arena constants and the sequencer state type.
// ----------------------------------------------------------------------------
package ascr_pkg;

  // fixed field widths
  localparam int IDX_W  = 4;
  localparam int POS_W  = 16;
  localparam int HALF_W = 15;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 15;
  localparam int CFG_IDX_W = 2;

  // width of box edges at full precision (position +/- half, wall faces)
  localparam int EXT_W = 19;

  // width of a cell id, wide enough for the largest table
  localparam int SEL_W = 9;

  // table size default
  localparam int MAX_SUBJECTS_DEF = 16;

  // arena constants, Q8.8
  localparam int WALL_THICK  = 256;
  localparam int WALL_HEIGHT = 512;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBE_HALF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HALF   = 2'd2;

  // configuration reset values
  localparam logic [CNT_W-1:0]  ACTIVE_COUNT_RST = 5'd0;
  localparam logic [HALF_W-1:0] CUBE_HALF_RST    = 15'd128;
  localparam logic [HALF_W-1:0] FLOOR_HALF_RST   = 15'd2560;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // one input item
  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_z;
    logic                    alive;
  } item_t;

  // one result item
  typedef struct packed {
    logic [IDX_W-1:0]        mover;
    logic signed [POS_W-1:0] final_x;
    logic signed [POS_W-1:0] final_z;
    logic                    x_reverted;
    logic                    z_reverted;
    logic                    rejected;
  } result_t;

  // query broadcast to every cell
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [IDX_W-1:0]        mover;
    logic [HALF_W-1:0]       half;
    logic [CNT_W-1:0]        count;
  } query_t;

  // table write control broadcast to every cell
  typedef struct packed {
    logic                    load;
    logic                    move_wr;
    logic [IDX_W-1:0]        index;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    alive;
  } wr_ctl_t;

  // move sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XCHK,
    ST_XRES,
    ST_ZCHK,
    ST_ZRES
  } state_t;

endpackage

// ===== design/ascr_cell.sv =====
// ----------------------------------------------------------------------------
// ascr_cell: one subject entry of the table
// Holds position and alive flag, takes loads and move write-backs, and
// registers whether its cube overlaps the broadcast mover box.
// ----------------------------------------------------------------------------
module ascr_cell
  import ascr_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wr_ctl_t                 wr,
  input  query_t                  q,
  output logic                    hit,
  output logic signed [POS_W-1:0] y_sel
);

  localparam logic [SEL_W-1:0] ID = SEL_W'(CELL_ID);

  logic signed [POS_W-1:0] x;
  logic signed [POS_W-1:0] y;
  logic signed [POS_W-1:0] z;
  logic                    alive;

  logic                    wr_sel;
  logic                    is_mover;
  logic                    enabled;
  logic signed [EXT_W-1:0] dx;
  logic signed [EXT_W-1:0] dy;
  logic signed [EXT_W-1:0] dz;
  logic signed [EXT_W-1:0] edge2;
  logic                    overlap;

  assign wr_sel   = (ID == SEL_W'(wr.index));
  assign is_mover = (ID == SEL_W'(q.mover));

  // alive flag is control state, positions are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (wr.load && wr_sel) begin
      alive <= wr.alive;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.load && wr_sel) begin
      x <= wr.x;
      y <= wr.y;
      z <= wr.z;
    end else if (wr.move_wr && wr_sel) begin
      x <= wr.x;
      z <= wr.z;
    end
  end

  // strict overlap of two equal cubes: |delta| < 2*half on every axis
  always_comb begin
    edge2   = $signed({3'b000, q.half, 1'b0});
    dx      = EXT_W'(q.x) - EXT_W'(x);
    dy      = EXT_W'(q.y) - EXT_W'(y);
    dz      = EXT_W'(q.z) - EXT_W'(z);
    overlap = (dx < edge2) && (-dx < edge2) &&
              (dy < edge2) && (-dy < edge2) &&
              (dz < edge2) && (-dz < edge2);
    enabled = alive && !is_mover && (ID < SEL_W'(q.count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= enabled && overlap;
    end
  end

  // mover's own height for the query
  assign y_sel = is_mover ? y : '0;

endmodule

// ===== design/ascr_walls.sv =====
// ----------------------------------------------------------------------------
// ascr_walls: overlap test of the mover box against the four arena walls
// Walls are one unit thick and two units high, standing on the floor level
// of a cube resting at height zero.
// ----------------------------------------------------------------------------
module ascr_walls
  import ascr_pkg::*;
(
  input  query_t q,
  input  logic [HALF_W-1:0] floor_half,
  output logic              hit
);

  function automatic logic span_hit(input logic signed [EXT_W-1:0] alo,
                                    input logic signed [EXT_W-1:0] ahi,
                                    input logic signed [EXT_W-1:0] blo,
                                    input logic signed [EXT_W-1:0] bhi);
    span_hit = (alo < bhi) && (ahi > blo);
  endfunction

  logic signed [EXT_W-1:0] h;
  logic signed [EXT_W-1:0] f;
  logic signed [EXT_W-1:0] o;
  logic signed [EXT_W-1:0] bot;
  logic signed [EXT_W-1:0] top;
  logic signed [EXT_W-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  logic                    y_in;
  logic                    w_px, w_nx, w_pz, w_nz;

  always_comb begin
    // arena faces
    h   = $signed({4'b0000, q.half});
    f   = $signed({4'b0000, floor_half});
    o   = f + EXT_W'(WALL_THICK);
    bot = -h;
    top = bot + EXT_W'(WALL_HEIGHT);
    // mover box edges
    x_lo = EXT_W'(q.x) - h;
    x_hi = EXT_W'(q.x) + h;
    y_lo = EXT_W'(q.y) - h;
    y_hi = EXT_W'(q.y) + h;
    z_lo = EXT_W'(q.z) - h;
    z_hi = EXT_W'(q.z) + h;
    // all walls share the height range
    y_in = span_hit(y_lo, y_hi, bot, top);
    w_px = span_hit(x_lo, x_hi, f, o)   && span_hit(z_lo, z_hi, -o, o);
    w_nx = span_hit(x_lo, x_hi, -o, -f) && span_hit(z_lo, z_hi, -o, o);
    w_pz = span_hit(x_lo, x_hi, -f, f)  && span_hit(z_lo, z_hi, f, o);
    w_nz = span_hit(x_lo, x_hi, -f, f)  && span_hit(z_lo, z_hi, -o, -f);
    hit  = y_in && (w_px || w_nx || w_pz || w_nz);
  end

endmodule

// ===== design/aabb_slide_collision_resolve_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_slide_collision_resolve_unit: slide resolution of cube moves
// Keeps a row of subject cells and resolves a move one axis at a time
// against the arena walls and every other alive subject below active_count.
// ----------------------------------------------------------------------------
// Usage
//   An item is taken on a rising edge with start high and busy low. A load
//   item (cmd = 0) writes one table entry in that edge and gives no result;
//   busy stays low, so loads may follow every cycle. A move item (cmd = 1)
//   gives exactly one result: done is high for one cycle with result valid.
//   A rejected move (index not below active_count) shows its result in the
//   cycle after the accept and keeps busy low.
//   Any other move raises busy while the mover box is broadcast to
//   all cells, which register their hits, the hits are merged to settle x,
//   then the same two steps settle z. done and the result appear in the
//   same cycle that busy falls, when the next item can already be taken.
//   Configuration is written through cfg_we, cfg_index and cfg_data while
//   the unit is idle. Reset clears the alive flags, sets the config registers
//   to defaults and returns the sequencer to idle; positions stay undefined
//   until loaded. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module aabb_slide_collision_resolve_unit
  import ascr_pkg::*;
#(
  parameter int MAX_SUBJECTS = MAX_SUBJECTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [CNT_W-1:0]  active_count;
  logic [HALF_W-1:0] cube_half;
  logic [HALF_W-1:0] floor_half;

  // sequencer
  state_t state;
  state_t state_next;

  // latched move
  logic [IDX_W-1:0]        mover_idx;
  logic signed [POS_W-1:0] mv_x;
  logic signed [POS_W-1:0] mv_z;
  logic signed [POS_W-1:0] prv_x;
  logic signed [POS_W-1:0] prv_z;
  logic signed [POS_W-1:0] mv_y;
  logic signed [POS_W-1:0] fx;
  logic                    xr;

  // control from the sequencer
  logic accept;
  logic accept_move;
  logic reject;
  logic latch_y;
  logic settle_x;
  logic settle_z;

  // datapath
  query_t                  q;
  wr_ctl_t                 wr;
  logic                    wall_hit_c;
  logic                    wall_hit;
  logic [MAX_SUBJECTS-1:0] cell_hit;
  logic signed [POS_W-1:0] cell_y [MAX_SUBJECTS];
  logic signed [POS_W-1:0] y_mux;
  logic                    blocked;
  logic signed [POS_W-1:0] fz;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ACTIVE_COUNT_RST;
      cube_half    <= CUBE_HALF_RST;
      floor_half   <= FLOOR_HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_COUNT: active_count <= cfg_data[CNT_W-1:0];
        CFG_CUBE_HALF:    cube_half    <= cfg_data[HALF_W-1:0];
        CFG_FLOOR_HALF:   floor_half   <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // acceptance and reject check
  assign accept = start && !busy;
  assign reject = (SEL_W'(item.index) >= SEL_W'(active_count)) ||
                  (SEL_W'(item.index) >= SEL_W'(MAX_SUBJECTS));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    accept_move = 1'b0;
    latch_y     = 1'b0;
    settle_x    = 1'b0;
    settle_z    = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && item.cmd == CMD_MOVE && !reject) begin
          accept_move = 1'b1;
          state_next  = ST_XCHK;
        end
      end
      ST_XCHK: begin
        latch_y    = 1'b1;
        state_next = ST_XRES;
      end
      ST_XRES: begin
        settle_x   = 1'b1;
        state_next = ST_ZCHK;
      end
      ST_ZCHK: begin
        state_next = ST_ZRES;
      end
      ST_ZRES: begin
        settle_z   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // query broadcast: moved x with previous z, then settled x with moved z
  always_comb begin
    q.mover = mover_idx;
    q.half  = cube_half;
    q.count = active_count;
    if (state == ST_XCHK || state == ST_XRES) begin
      q.x = mv_x;
      q.y = y_mux;
      q.z = prv_z;
    end else begin
      q.x = fx;
      q.y = mv_y;
      q.z = mv_z;
    end
  end

  // table writes: loads at accept, write-back at the end of a move
  always_comb begin
    wr.load    = accept && item.cmd == CMD_LOAD;
    wr.move_wr = settle_z;
    wr.alive   = item.alive;
    wr.y       = item.pos_y;
    if (settle_z) begin
      wr.index = mover_idx;
      wr.x     = fx;
      wr.z     = fz;
    end else begin
      wr.index = item.index;
      wr.x     = item.pos_x;
      wr.z     = item.pos_z;
    end
  end

  // row of subject cells
  for (genvar i = 0; i < MAX_SUBJECTS; i++) begin : g_cell
    ascr_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .wr    (wr),
      .q     (q),
      .hit   (cell_hit[i]),
      .y_sel (cell_y[i])
    );
  end

  // mover height: only the mover's cell drives a nonzero value
  always_comb begin
    y_mux = '0;
    for (int i = 0; i < MAX_SUBJECTS; i++) begin
      y_mux = y_mux | cell_y[i];
    end
  end

  // wall test, registered alongside the cell hits
  ascr_walls u_walls (
    .q          (q),
    .floor_half (floor_half),
    .hit        (wall_hit_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_hit <= 1'b0;
    end else begin
      wall_hit <= wall_hit_c;
    end
  end

  // merge of registered hits
  assign blocked = wall_hit || (|cell_hit);
  assign fz      = blocked ? prv_z : mv_z;

  // move registers
  always_ff @(posedge clk) begin
    if (accept_move) begin
      mover_idx <= item.index;
      mv_x      <= item.pos_x;
      mv_z      <= item.pos_z;
      prv_x     <= item.prev_x;
      prv_z     <= item.prev_z;
    end
    if (latch_y) begin
      mv_y <= y_mux;
    end
    if (settle_x) begin
      fx <= blocked ? prv_x : mv_x;
      xr <= blocked;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= settle_z || (accept && item.cmd == CMD_MOVE && reject);
    end
  end

  always_ff @(posedge clk) begin
    if (settle_z) begin
      result.mover      <= mover_idx;
      result.final_x    <= fx;
      result.final_z    <= fz;
      result.x_reverted <= xr;
      result.z_reverted <= blocked;
      result.rejected   <= 1'b0;
    end else if (accept) begin
      result.mover      <= item.index;
      result.final_x    <= '0;
      result.final_z    <= '0;
      result.x_reverted <= 1'b0;
      result.z_reverted <= 1'b0;
      result.rejected   <= 1'b1;
    end
  end

endmodule

// ===== tb/sv/aabb_slide_collision_resolve_unit_tb.sv =====
// ----------------------------------------------------------------------------
// aabb_slide_collision_resolve_unit_tb: self-checking bench of the resolver
// Fills the subject table, runs directed wall, cube, touch and extreme moves,
// then random load and move traffic over several register settings. A local
// predictor resolves each accepted item and every done strobe is checked
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module aabb_slide_collision_resolve_unit_tb;
  import ascr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 145;
  localparam int PHASES         = 6;

  // box edges at full precision
  typedef logic signed [EXT_W-1:0] edge_t;
  typedef struct packed {
    edge_t x0, y0, z0, x1, y1, z1;
  } box_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                item = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor copy of registers and subject table
  logic [CNT_W-1:0]        act_cnt  = ACTIVE_COUNT_RST;
  logic [HALF_W-1:0]       half_len = CUBE_HALF_RST;
  logic [HALF_W-1:0]       floor_in = FLOOR_HALF_RST;
  logic signed [POS_W-1:0] tbl_x [MAX_SUBJECTS_DEF];
  logic signed [POS_W-1:0] tbl_y [MAX_SUBJECTS_DEF];
  logic signed [POS_W-1:0] tbl_z [MAX_SUBJECTS_DEF];
  logic                    tbl_alive [MAX_SUBJECTS_DEF] = '{default: 1'b0};

  // nominal positions used to shape well-formed moves
  int gen_x [MAX_SUBJECTS_DEF];
  int gen_z [MAX_SUBJECTS_DEF];

  item_t   cmd_queue[$];
  result_t moves_awaited[$];
  int      idle_pct = 0;
  int      errors = 0;
  int      quiet = 0;
  int      n_loads = 0, n_moves = 0, n_rejected = 0, n_xrev = 0, n_zrev = 0;

  aabb_slide_collision_resolve_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cube of the current half edge around a point
  function automatic box_t cube_box(input edge_t x, input edge_t y, input edge_t z);
    box_t  b;
    edge_t h;
    h = edge_t'(half_len);
    b = '{x - h, y - h, z - h, x + h, y + h, z + h};
    return b;
  endfunction

  // strict overlap on every axis, touching faces do not count
  function automatic bit overlaps(input box_t a, input box_t b);
    return (a.x0 < b.x1) && (a.x1 > b.x0) && (a.y0 < b.y1) && (a.y1 > b.y0) &&
           (a.z0 < b.z1) && (a.z1 > b.z0);
  endfunction

  // mover box against the four walls and every other alive subject
  function automatic bit blocked(input int mi, input edge_t x, input edge_t y,
                                 input edge_t z);
    box_t  m;
    box_t  walls [4];
    edge_t f, o, bot, top;
    int    n;
    m   = cube_box(x, y, z);
    f   = edge_t'(floor_in);
    o   = f + edge_t'(WALL_THICK);
    bot = -edge_t'(half_len);
    top = bot + edge_t'(WALL_HEIGHT);
    walls[0] = '{f, bot, -o, o, top, o};
    walls[1] = '{-o, bot, -o, -f, top, o};
    walls[2] = '{-f, bot, f, f, top, o};
    walls[3] = '{-f, bot, -o, f, top, -f};
    for (int w = 0; w < 4; w++) begin
      if (overlaps(m, walls[w])) return 1'b1;
    end
    n = (int'(act_cnt) > MAX_SUBJECTS_DEF) ? MAX_SUBJECTS_DEF : int'(act_cnt);
    for (int i = 0; i < n; i++) begin
      if (i != mi && tbl_alive[i] &&
          overlaps(m, cube_box(edge_t'(tbl_x[i]), edge_t'(tbl_y[i]), edge_t'(tbl_z[i]))))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // update the table for one accepted item and queue the result it causes
  function automatic void resolve_item(input item_t it);
    result_t r;
    edge_t   y, fx, fz;
    int      mi;
    mi = int'(it.index);
    if (it.cmd == CMD_LOAD) begin
      tbl_x[mi] = it.pos_x;
      tbl_y[mi] = it.pos_y;
      tbl_z[mi] = it.pos_z;
      tbl_alive[mi] = it.alive;
      n_loads++;
      return;
    end
    n_moves++;
    r = '0;
    r.mover = it.index;
    if (it.index >= act_cnt) begin
      r.rejected = 1'b1;
      n_rejected++;
      moves_awaited.push_back(r);
      return;
    end
    y  = edge_t'(tbl_y[mi]);
    fx = edge_t'(it.pos_x);
    if (blocked(mi, fx, y, edge_t'(it.prev_z))) begin
      fx = edge_t'(it.prev_x);
      r.x_reverted = 1'b1;
      n_xrev++;
    end
    fz = edge_t'(it.pos_z);
    if (blocked(mi, fx, y, fz)) begin
      fz = edge_t'(it.prev_z);
      r.z_reverted = 1'b1;
      n_zrev++;
    end
    tbl_x[mi] = fx[POS_W-1:0];
    tbl_z[mi] = fz[POS_W-1:0];
    r.final_x = fx[POS_W-1:0];
    r.final_z = fz[POS_W-1:0];
    moves_awaited.push_back(r);
  endfunction

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void queue_load(input int idx, input int x, input int y, input int z,
                                     input bit alive);
    item_t it;
    it = '0;
    it.cmd    = CMD_LOAD;
    it.index  = IDX_W'(idx);
    it.pos_x  = POS_W'(x);
    it.pos_y  = POS_W'(y);
    it.pos_z  = POS_W'(z);
    it.prev_x = POS_W'($urandom);
    it.prev_z = POS_W'($urandom);
    it.alive  = alive;
    cmd_queue.push_back(it);
    gen_x[idx] = x;
    gen_z[idx] = z;
  endfunction

  function automatic void queue_move(input int idx, input int px, input int py, input int pz,
                                     input int qx, input int qz);
    item_t it;
    it.cmd    = CMD_MOVE;
    it.index  = IDX_W'(idx);
    it.pos_x  = POS_W'(px);
    it.pos_y  = POS_W'(py);
    it.pos_z  = POS_W'(pz);
    it.prev_x = POS_W'(qx);
    it.prev_z = POS_W'(qz);
    it.alive  = 1'($urandom);
    cmd_queue.push_back(it);
    gen_x[idx] = px;
    gen_z[idx] = pz;
  endfunction

  // random traffic: mostly moves near the nominal position, some loads, some noise
  function automatic void fill_random(input int count);
    item_t it;
    int    lim, span, step, sel, idx, h, ly;
    lim  = (int'(act_cnt) > MAX_SUBJECTS_DEF) ? MAX_SUBJECTS_DEF : int'(act_cnt);
    span = int'(floor_in) + 512;
    h    = int'(half_len) + 1;
    step = 2 * int'(half_len) + 64;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        it.cmd    = 1'($urandom);
        it.index  = IDX_W'($urandom);
        it.pos_x  = POS_W'($urandom);
        it.pos_y  = POS_W'($urandom);
        it.pos_z  = POS_W'($urandom);
        it.prev_x = POS_W'($urandom);
        it.prev_z = POS_W'($urandom);
        it.alive  = 1'($urandom);
        cmd_queue.push_back(it);
      end else if (sel < 20) begin
        idx = $urandom_range(MAX_SUBJECTS_DEF - 1);
        ly  = ($urandom_range(9) < 7) ? 0 : int'($urandom_range(2 * h)) - h;
        queue_load(idx, clip16(int'($urandom_range(2 * span)) - span), clip16(ly),
                   clip16(int'($urandom_range(2 * span)) - span),
                   $urandom_range(99) < 85);
      end else begin
        if (lim > 0 && $urandom_range(9) < 8) idx = $urandom_range(lim - 1);
        else idx = $urandom_range(MAX_SUBJECTS_DEF - 1);
        queue_move(idx, clip16(gen_x[idx] + int'($urandom_range(2 * step)) - step),
                   int'($urandom_range(65535)) - 32768,
                   clip16(gen_z[idx] + int'($urandom_range(2 * step)) - step),
                   gen_x[idx], gen_z[idx]);
      end
    end
  endfunction

  // register write, only called while the unit is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_ACTIVE_COUNT: act_cnt = data[CNT_W-1:0];
      CFG_CUBE_HALF:    half_len = data[HALF_W-1:0];
      CFG_FLOOR_HALF:   floor_in = data[HALF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every queued item to be taken and every result to arrive
  task automatic settle();
    while (cmd_queue.size() != 0 || start || moves_awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void flag_error(input string msg);
    if (errors < 10) $display("ERROR: %s", msg);
    errors++;
  endfunction

  // driver: predict on accept, then offer the next item unless idling
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) resolve_item(item);
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          item  <= cmd_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done strobe against the oldest predicted result
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (moves_awaited.size() == 0) begin
        flag_error($sformatf("unexpected result mover=%0d x=%0d z=%0d xr=%b zr=%b rej=%b",
                             result.mover, result.final_x, result.final_z,
                             result.x_reverted, result.z_reverted, result.rejected));
      end else begin
        want = moves_awaited.pop_front();
        if (result.mover !== want.mover || result.final_x !== want.final_x ||
            result.final_z !== want.final_z || result.x_reverted !== want.x_reverted ||
            result.z_reverted !== want.z_reverted || result.rejected !== want.rejected)
          flag_error($sformatf({"mover=%0d x=%0d z=%0d xr=%b zr=%b rej=%b, ",
                                "got mover=%0d x=%0d z=%0d xr=%b zr=%b rej=%b"},
                               want.mover, want.final_x, want.final_z, want.x_reverted,
                               want.z_reverted, want.rejected, result.mover,
                               result.final_x, result.final_z, result.x_reverted,
                               result.z_reverted, result.rejected));
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1 || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", moves_awaited.size());
      $display("aabb_slide_collision_resolve_unit_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // move with no active subjects is refused
    queue_move(0, 100, 0, 100, 0, 0);
    settle();
    write_reg(CFG_ACTIVE_COUNT, CFG_W'(16));
    write_reg(CFG_CUBE_HALF, CFG_W'(128));
    write_reg(CFG_FLOOR_HALF, CFG_W'(2560));

    // 4 x 4 grid, one alive cube far below, one dead entry
    for (int i = 0; i < MAX_SUBJECTS_DEF; i++) begin
      queue_load(i, (i % 4) * 1024 - 1536, (i == 14) ? -32768 : ((i == 15) ? 32767 : 0),
                 (i / 4) * 1024 - 1536, i != 15);
    end
    // free move, touching faces, blocked by a cube
    queue_move(0, -1500, 0, -1500, -1536, -1536);
    queue_move(0, -768, 0, -1500, -1500, -1500);
    queue_move(0, -700, 0, -1400, -768, -1500);
    // walls: x only, then both axes
    queue_move(3, 2500, 0, -1500, 1536, -1536);
    queue_move(12, -2500, 0, 2500, -1536, 1536);
    // mover on its own stored spot
    queue_move(5, -512, 0, -512, -512, -512);
    // onto a cube that is vertically apart, onto a dead entry
    queue_move(10, 512, 0, 1536, 512, 512);
    queue_move(11, 1536, 0, 1536, 1536, 512);
    // field extremes
    queue_move(1, 32767, 32767, -32768, -32768, 32767);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      idle_pct = 0;
      case (p)
        0: begin
          write_reg(CFG_ACTIVE_COUNT, CFG_W'(16));
          write_reg(CFG_CUBE_HALF, CFG_W'(128));
          write_reg(CFG_FLOOR_HALF, CFG_W'(2560));
        end
        1: begin
          write_reg(CFG_ACTIVE_COUNT, CFG_W'(31));
          write_reg(CFG_CUBE_HALF, CFG_W'(300));
          write_reg(CFG_FLOOR_HALF, CFG_W'(1500));
        end
        2: begin
          write_reg(CFG_ACTIVE_COUNT, CFG_W'(7));
          write_reg(CFG_CUBE_HALF, CFG_W'(0));
          write_reg(CFG_FLOOR_HALF, CFG_W'(32767));
        end
        3: begin
          write_reg(CFG_ACTIVE_COUNT, CFG_W'(12));
          write_reg(CFG_CUBE_HALF, CFG_W'(32767));
          write_reg(CFG_FLOOR_HALF, CFG_W'(0));
        end
        4: begin
          write_reg(CFG_ACTIVE_COUNT, CFG_W'($urandom_range(15, 1)));
          write_reg(CFG_CUBE_HALF, CFG_W'($urandom_range(512, 64)));
          write_reg(CFG_FLOOR_HALF, CFG_W'($urandom_range(4096, 768)));
        end
        default: begin
          // upper data bits are don't care for the count
          write_reg(CFG_ACTIVE_COUNT, {10'($urandom), 5'd16});
          write_reg(CFG_CUBE_HALF, CFG_W'($urandom_range(1023, 16)));
          write_reg(CFG_FLOOR_HALF, CFG_W'($urandom_range(32767)));
        end
      endcase
      case (p % 4)
        1: idle_pct = 85;
        3: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      fill_random(PHASE_ITEMS);
    end
    settle();

    $display("covered %0d loads and %0d moves over %0d register settings", n_loads, n_moves,
             PHASES + 1);
    $display("moves: %0d refused, %0d x reverts, %0d z reverts, %0d mismatches", n_rejected,
             n_xrev, n_zrev, errors);
    if (errors == 0 && moves_awaited.size() == 0) begin
      $display("aabb_slide_collision_resolve_unit_tb OK");
    end else begin
      $display("aabb_slide_collision_resolve_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
